>>> sv/nearest_peak_within_tolerance_macros.svh
// ----------------------------------------------------------------------------
// nearest peak within tolerance - assertion macros
// concurrent check helpers on clk_i with rst_ni as disable
// ----------------------------------------------------------------------------
`ifndef NEAREST_PEAK_WITHIN_TOLERANCE_MACROS_SVH
`define NEAREST_PEAK_WITHIN_TOLERANCE_MACROS_SVH

// same-cycle implication
`define NPWT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NPWT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/npwt_pkg.sv
// ----------------------------------------------------------------------------
// npwt_pkg
// shared types and constants of the nearest peak lookup
// ----------------------------------------------------------------------------
package npwt_pkg;

  localparam int MZ_W      = 32;
  localparam int REQ_W     = 2;
  localparam int IDX_OUT_W = 10;

  localparam logic [MZ_W-1:0] TOL_RESET = 32'd20972;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_QUERY  = 2'd2
  } req_e;

endpackage

>>> sv/npwt_ram.sv
// ----------------------------------------------------------------------------
// npwt_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module npwt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/npwt_cmp.sv
// ----------------------------------------------------------------------------
// npwt_cmp
// shared compare unit: unsigned less-than and absolute difference
// ----------------------------------------------------------------------------
module npwt_cmp (
  input  logic [npwt_pkg::MZ_W-1:0] a_i,
  input  logic [npwt_pkg::MZ_W-1:0] b_i,
  output logic                      lt_o,
  output logic [npwt_pkg::MZ_W-1:0] diff_o
);

  import npwt_pkg::*;

  assign lt_o   = a_i < b_i;
  assign diff_o = lt_o ? (b_i - a_i) : (a_i - b_i);

endmodule

>>> sv/nearest_peak_within_tolerance.sv
// ----------------------------------------------------------------------------
// nearest_peak_within_tolerance
// ascending peak store with binary search for the nearest peak in tolerance
//
// channel   direction  transfer when                 payload
// request   in         start & !busy                 req_type_i peak_mz_i query_mz_i
// result    out        done_o (one cycle, no stall)  found_o peak_index_o matched_mz_o
//                                                    store_full_o
// config    in         cfg_valid_i & cfg_ready_o     cfg_data_i (match tolerance)
//
// clear, append, unused codes, query on empty store: result in the cycle after the
// transfer, busy stays low; query: binary search steps, then upper and lower
// neighbour distances, pick and tolerance check; paced by the single ram read port
// and the one shared compare unit
// asynchronous active-low reset empties the store; no clearing pass
// the result is shown for one cycle only and cannot be held off
// ----------------------------------------------------------------------------
`include "nearest_peak_within_tolerance_macros.svh"

module nearest_peak_within_tolerance #(
  parameter int MAX_PEAKS = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [npwt_pkg::REQ_W-1:0]     req_type_i,
  input  logic [npwt_pkg::MZ_W-1:0]      peak_mz_i,
  input  logic [npwt_pkg::MZ_W-1:0]      query_mz_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [npwt_pkg::MZ_W-1:0]      cfg_data_i,
  output logic                           done_o,
  output logic                           found_o,
  output logic [npwt_pkg::IDX_OUT_W-1:0] peak_index_o,
  output logic [npwt_pkg::MZ_W-1:0]      matched_mz_o,
  output logic                           store_full_o
);

  import npwt_pkg::*;

  localparam int IDX_W = $clog2(MAX_PEAKS);
  localparam int CNT_W = $clog2(MAX_PEAKS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PEAKS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_UPPER,
    S_LOWER,
    S_PICK,
    S_TOL
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] count_q;
  logic [MZ_W-1:0]  tol_q;
  logic [MZ_W-1:0]  q_q;
  logic [CNT_W-1:0] lo_q;
  logic [CNT_W-1:0] hi_q;
  logic [CNT_W-1:0] mid_q;
  logic [IDX_W-1:0] best_q;
  logic [MZ_W-1:0]  dist_q;
  logic [MZ_W-1:0]  cand_mz_q;
  logic [MZ_W-1:0]  alt_dist_q;
  logic [MZ_W-1:0]  alt_mz_q;
  logic             done_q;
  logic             found_q;
  logic [IDX_W-1:0] pidx_q;
  logic [MZ_W-1:0]  mz_q;
  logic             full_q;

  logic             accept;
  logic             is_full;
  logic             ram_we;
  logic [IDX_W-1:0] raddr;
  logic [MZ_W-1:0]  rdata;
  logic [MZ_W-1:0]  cmp_a;
  logic [MZ_W-1:0]  cmp_b;
  logic             cmp_lt;
  logic [MZ_W-1:0]  cmp_diff;
  logic [CNT_W-1:0] mid0;
  logic [CNT_W-1:0] lo_n;
  logic [CNT_W-1:0] hi_n;
  logic [CNT_W:0]   sum_n;
  logic [CNT_W-1:0] mid_n;
  logic             srch_more;
  logic [CNT_W-1:0] first_cand;
  logic [IDX_W+IDX_OUT_W-1:0] pidx_ext;
  logic             query_go;
  logic [MZ_W-1:0]  match_dist;

  assign accept      = start && !busy;
  assign busy        = state_q != S_IDLE;
  assign cfg_ready_o = 1'b1;
  assign is_full     = count_q == CNT_MAX;
  assign ram_we      = accept && (req_e'(req_type_i) == REQ_APPEND) && !is_full;

  npwt_ram #(
    .WIDTH (MZ_W),
    .DEPTH (MAX_PEAKS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (peak_mz_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  npwt_cmp u_cmp (
    .a_i    (cmp_a),
    .b_i    (cmp_b),
    .lt_o   (cmp_lt),
    .diff_o (cmp_diff)
  );

  // search step arithmetic
  assign mid0       = count_q >> 1;
  assign lo_n       = cmp_lt ? (mid_q + CNT_W'(1)) : lo_q;
  assign hi_n       = cmp_lt ? hi_q : mid_q;
  assign sum_n      = {1'b0, lo_n} + {1'b0, hi_n};
  assign mid_n      = sum_n[CNT_W:1];
  assign srch_more  = lo_n < hi_n;
  assign first_cand = (lo_n < count_q) ? lo_n : (lo_n - CNT_W'(1));

  always_comb begin
    cmp_a = rdata;
    cmp_b = q_q;
    raddr = mid0[IDX_W-1:0];
    unique case (state_q)
      S_IDLE: begin
        raddr = mid0[IDX_W-1:0];
      end
      S_SRCH: begin
        raddr = srch_more ? mid_n[IDX_W-1:0] : first_cand[IDX_W-1:0];
      end
      S_UPPER: begin
        raddr = IDX_W'(lo_q - CNT_W'(1));
      end
      S_LOWER: begin
        raddr = best_q;
      end
      S_PICK: begin
        cmp_a = alt_dist_q;
        cmp_b = dist_q;
      end
      S_TOL: begin
        cmp_a = tol_q;
        cmp_b = dist_q;
      end
      default: begin
        cmp_a = rdata;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      tol_q      <= TOL_RESET;
      q_q        <= '0;
      lo_q       <= '0;
      hi_q       <= '0;
      mid_q      <= '0;
      best_q     <= '0;
      dist_q     <= '0;
      cand_mz_q  <= '0;
      alt_dist_q <= '0;
      alt_mz_q   <= '0;
      done_q     <= 1'b0;
      found_q    <= 1'b0;
      pidx_q     <= '0;
      mz_q       <= '0;
      full_q     <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        tol_q <= cfg_data_i;
      end
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            q_q     <= query_mz_i;
            found_q <= 1'b0;
            pidx_q  <= '0;
            mz_q    <= '0;
            full_q  <= 1'b0;
            done_q  <= 1'b1;
            unique case (req_e'(req_type_i))
              REQ_CLEAR: begin
                count_q <= '0;
              end
              REQ_APPEND: begin
                if (is_full) begin
                  full_q <= 1'b1;
                end else begin
                  count_q <= count_q + CNT_W'(1);
                end
              end
              REQ_QUERY: begin
                if (count_q != '0) begin
                  done_q  <= 1'b0;
                  lo_q    <= '0;
                  hi_q    <= count_q;
                  mid_q   <= mid0;
                  state_q <= S_SRCH;
                end
              end
              default: begin
                full_q <= 1'b0;
              end
            endcase
          end
        end
        S_SRCH: begin
          lo_q  <= lo_n;
          hi_q  <= hi_n;
          mid_q <= mid_n;
          if (!srch_more) begin
            best_q  <= first_cand[IDX_W-1:0];
            state_q <= S_UPPER;
          end
        end
        S_UPPER: begin
          dist_q    <= cmp_diff;
          cand_mz_q <= rdata;
          if ((lo_q < count_q) && (lo_q != '0)) begin
            state_q <= S_LOWER;
          end else begin
            state_q <= S_TOL;
          end
        end
        S_LOWER: begin
          alt_dist_q <= cmp_diff;
          alt_mz_q   <= rdata;
          state_q    <= S_PICK;
        end
        S_PICK: begin
          // lower neighbour only on strictly smaller distance
          if (cmp_lt) begin
            dist_q    <= alt_dist_q;
            cand_mz_q <= alt_mz_q;
            best_q    <= best_q - IDX_W'(1);
          end
          state_q <= S_TOL;
        end
        S_TOL: begin
          done_q <= 1'b1;
          if (!cmp_lt) begin
            found_q <= 1'b1;
            pidx_q  <= best_q;
            mz_q    <= cand_mz_q;
          end
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign pidx_ext     = {IDX_OUT_W'(0), pidx_q};
  assign done_o       = done_q;
  assign found_o      = found_q;
  assign peak_index_o = pidx_ext[IDX_OUT_W-1:0];
  assign matched_mz_o = mz_q;
  assign store_full_o = full_q;

  assign query_go   = accept && (req_type_i == REQ_QUERY) && (count_q != '0);
  assign match_dist = (matched_mz_o >= q_q) ? (matched_mz_o - q_q) : (q_q - matched_mz_o);

  `NPWT_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CNT_MAX, "peak count above store depth")
  `NPWT_ASSERT_IMPL(a_found_full_excl, done_o, !(found_o && store_full_o), "found and full")
  `NPWT_ASSERT_NEXT(a_query_busy, query_go, busy, "query on filled store did not start search")
  `NPWT_ASSERT_IMPL(a_match_in_tol, done_o && found_o, match_dist <= tol_q, "peak out of tolerance")

endmodule
